@@ hw/rtl/sme_pkg.sv @@
// shared types and codes of the stack machine executor
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

  typedef enum logic [4:0] {
    K_LDC    = 5'd0,
    K_LDV    = 5'd1,
    K_ADD    = 5'd2,
    K_SUB    = 5'd3,
    K_MULT   = 5'd4,
    K_DIVI   = 5'd5,
    K_INV    = 5'd6,
    K_AND    = 5'd7,
    K_OR     = 5'd8,
    K_NEG    = 5'd9,
    K_CME    = 5'd10,
    K_CMA    = 5'd11,
    K_CEQ    = 5'd12,
    K_CDIF   = 5'd13,
    K_CMEQ   = 5'd14,
    K_CMAQ   = 5'd15,
    K_STR    = 5'd16,
    K_JMP    = 5'd17,
    K_JMPF   = 5'd18,
    K_NOP    = 5'd19,
    K_RD     = 5'd20,
    K_PRN    = 5'd21,
    K_CALL   = 5'd22,
    K_RETURN = 5'd23,
    K_ALLOC  = 5'd24,
    K_DALLOC = 5'd25,
    K_HLT    = 5'd26,
    K_DEFINE = 5'd27
  } sme_kind_t;

  localparam logic [2:0] FAULT_NONE      = 3'd0;
  localparam logic [2:0] FAULT_UNDERFLOW = 3'd1;
  localparam logic [2:0] FAULT_OVERFLOW  = 3'd2;
  localparam logic [2:0] FAULT_DIV_ZERO  = 3'd3;
  localparam logic [2:0] FAULT_ADDRESS   = 3'd4;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_REM,
    ALU_AND,
    ALU_OR,
    ALU_LT,
    ALU_GT,
    ALU_EQ,
    ALU_NE,
    ALU_LE,
    ALU_GE
  } sme_alu_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ_X,
    S_READ_Y,
    S_EXEC,
    S_ALU,
    S_CP_RD,
    S_CP_WR
  } sme_state_t;

  typedef struct packed {
    logic [4:0]         kind;
    logic signed [31:0] operand_a;
    logic [9:0]         operand_b;
    logic signed [31:0] read_value;
  } sme_item_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               halted;
    logic [2:0]         fault;
  } sme_result_t;

  typedef struct packed {
    logic        start;
    sme_alu_op_t op;
    logic [31:0] x;
    logic [31:0] y;
  } sme_alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } sme_alu_rsp_t;

  localparam int DIV_STEPS = 32;

endpackage
`default_nettype wire

@@ hw/rtl/sme_div.sv @@
// iterative signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sme_div
  import sme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   acc;
  logic [31:0]   q;
  logic [31:0]   d;
  logic          neg_q;
  logic          neg_r;
  logic [32:0]   shifted;
  logic [32:0]   diff;
  logic          ge;

  assign shifted = {acc, q[31]};
  assign diff    = shifted - {1'b0, d};
  assign ge      = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        acc   <= '0;
        q     <= dividend[31] ? (32'd0 - dividend) : dividend;
        d     <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg_q <= dividend[31] ^ divisor[31];
        neg_r <= dividend[31];
      end else if (busy) begin
        acc <= ge ? diff[31:0] : shifted[31:0];
        q   <= {q[30:0], ge};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = neg_q ? (32'd0 - q) : q;
  assign remainder = neg_r ? (32'd0 - acc) : acc;

endmodule
`default_nettype wire

@@ hw/rtl/sme_alu.sv @@
// shared arithmetic and compare unit with registered result
`timescale 1ns / 1ps
`default_nettype none
module sme_alu
  import sme_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sme_alu_req_t req,
  output sme_alu_rsp_t      rsp
);

  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] div_r;
  logic        want_rem;
  logic [31:0] val;
  logic        is_div;

  assign is_div    = (req.op == ALU_DIV) || (req.op == ALU_REM);
  assign div_start = req.start && is_div;

  sme_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.x),
    .divisor   (req.y),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    case (req.op)
      ALU_ADD: val = req.x + req.y;
      ALU_SUB: val = req.x - req.y;
      ALU_MUL: val = req.x * req.y;
      ALU_AND: val = 32'((req.x != '0) && (req.y != '0));
      ALU_OR:  val = 32'((req.x != '0) || (req.y != '0));
      ALU_LT:  val = 32'($signed(req.x) <  $signed(req.y));
      ALU_GT:  val = 32'($signed(req.x) >  $signed(req.y));
      ALU_EQ:  val = 32'(req.x == req.y);
      ALU_NE:  val = 32'(req.x != req.y);
      ALU_LE:  val = 32'($signed(req.x) <= $signed(req.y));
      ALU_GE:  val = 32'($signed(req.x) >= $signed(req.y));
      default: val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start && !is_div) begin
        rsp.res  <= val;
        rsp.done <= 1'b1;
      end else if (div_done) begin
        rsp.res  <= want_rem ? div_r : div_q;
        rsp.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      want_rem <= (req.op == ALU_REM);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/stack_machine_executor.sv @@
// top level of the stack machine executor: sequencer, word memory and label table
`timescale 1ns / 1ps
`default_nettype none
// Executes one stack machine instruction per word taken on start while busy is low, and
// returns one result word on result with done high for exactly one cycle; the receiver
// cannot stall it. The sequencer reads the stack through a single word memory with a
// registered read port, so one instruction walks check, read and execute steps: a simple
// push, pop, jump, call, return, print or halt ends in execute, invert and not add an alu
// step, and a two-operand op reads a second operand and then, unless it divides by zero,
// runs through the shared alu; a divide also waits for the bit-serial divider. A label
// define ends in execute when the entry is skipped, else an alu step takes PROGRAM_DEPTH
// off the position until it is in range. Nonzero alloc and dealloc then copy one word per
// read and write step pair. Stack and address faults are found in the check step and finish
// there, as does every ignored word after halt; a bad return address and divide by zero are
// found in execute. After reset the label table is swept clear while busy stays high.
module stack_machine_executor
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH   = 1024,
  parameter int PROGRAM_DEPTH = 1024,
  parameter int LABEL_COUNT   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire sme_item_t   item,
  output logic             busy,
  output logic             done,
  output sme_result_t      result
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int PCW = $clog2(PROGRAM_DEPTH);
  localparam int LBW = $clog2(LABEL_COUNT);
  localparam int LEW = PCW + 1;

  function automatic logic [PCW-1:0] adv(input logic [PCW-1:0] p);
    adv = (p == PCW'(PROGRAM_DEPTH - 1)) ? '0 : p + PCW'(1);
  endfunction

  // word memory shared by data and stack
  logic [31:0]    mem [STACK_DEPTH];
  logic [AW-1:0]  mem_raddr;
  logic [31:0]    mem_rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;

  // label table: defined flag above the position
  logic [LEW-1:0] lab [LABEL_COUNT];
  logic [LBW-1:0] lab_raddr;
  logic [LEW-1:0] lab_rdata;
  logic           lab_we;
  logic [LBW-1:0] lab_waddr;
  logic [LEW-1:0] lab_wdata;

  sme_state_t     state, state_next;
  sme_item_t      item_r;
  logic [SPW-1:0] sp, sp_next;
  logic [PCW-1:0] pc, pc_next;
  logic           halt, halt_next;
  logic [9:0]     k, k_next;
  logic [31:0]    t, t_next;
  logic [31:0]    y, y_next;
  logic [LEW-1:0] lab_r, lab_r_next;
  logic [LBW-1:0] clr;

  sme_alu_req_t   alu_req;
  sme_alu_rsp_t   alu_rsp;

  // finish controls
  logic           fin;
  logic           go_alu;
  logic           o_pv;
  logic [31:0]    o_pval;
  logic [2:0]     o_fault;

  // decode of the held word
  sme_kind_t      kind;
  logic [31:0]    a;
  logic [9:0]     n;
  logic           is_bin;
  logic           full;
  logic           a_lt_sp;
  logic           a_n_le_sp;
  logic           alloc_ovf;
  logic           lab_in_range;
  logic           found;
  logic [PCW-1:0] jump_pc;
  logic [2:0]     fault_pre;
  logic [SPW-1:0] sp_m1, sp_m2;
  logic [AW-1:0]  a_addr;
  sme_alu_op_t    bin_op;

  sme_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign kind         = sme_kind_t'(item_r.kind);
  assign a            = item_r.operand_a;
  assign n            = item_r.operand_b;
  assign sp_m1        = sp - SPW'(1);
  assign sp_m2        = sp - SPW'(2);
  assign a_addr       = a[AW-1:0];
  assign full         = (sp >= SPW'(STACK_DEPTH));
  assign a_lt_sp      = !a[31] && ({1'b0, a[30:0]} < 32'(sp));
  assign a_n_le_sp    = !a[31] && ((33'({1'b0, a[30:0]}) + 33'(n)) <= 33'(sp));
  assign alloc_ovf    = (33'(sp) + 33'(n)) > 33'(STACK_DEPTH);
  assign lab_in_range = !a[31] && (a[30:0] < 31'(LABEL_COUNT));
  assign found        = lab_in_range && lab_r[PCW];
  assign jump_pc      = adv(lab_r[PCW-1:0]);

  always_comb begin
    case (kind) inside
      K_ADD, K_SUB, K_MULT, K_DIVI, K_AND, K_OR,
      [K_CME:K_CMAQ]: is_bin = 1'b1;
      default:        is_bin = 1'b0;
    endcase
  end

  always_comb begin
    case (kind)
      K_ADD:   bin_op = ALU_ADD;
      K_SUB:   bin_op = ALU_SUB;
      K_MULT:  bin_op = ALU_MUL;
      K_DIVI:  bin_op = ALU_DIV;
      K_AND:   bin_op = ALU_AND;
      K_OR:    bin_op = ALU_OR;
      K_CME:   bin_op = ALU_LT;
      K_CMA:   bin_op = ALU_GT;
      K_CEQ:   bin_op = ALU_EQ;
      K_CDIF:  bin_op = ALU_NE;
      K_CMEQ:  bin_op = ALU_LE;
      default: bin_op = ALU_GE;
    endcase
  end

  // checks in order: underflow, overflow, address
  always_comb begin
    fault_pre = FAULT_NONE;
    case (kind) inside
      K_LDC, K_RD, K_CALL: begin
        if (full) fault_pre = FAULT_OVERFLOW;
      end
      K_LDV: begin
        if (full) fault_pre = FAULT_OVERFLOW;
        else if (!a_lt_sp) fault_pre = FAULT_ADDRESS;
      end
      K_ADD, K_SUB, K_MULT, K_DIVI, K_AND, K_OR, [K_CME:K_CMAQ]: begin
        if (sp < SPW'(2)) fault_pre = FAULT_UNDERFLOW;
      end
      K_INV, K_NEG, K_JMPF, K_PRN, K_RETURN: begin
        if (sp == '0) fault_pre = FAULT_UNDERFLOW;
      end
      K_STR: begin
        if (sp == '0) fault_pre = FAULT_UNDERFLOW;
        else if (!a_lt_sp) fault_pre = FAULT_ADDRESS;
      end
      K_ALLOC: begin
        if (n != '0) begin
          if (alloc_ovf) fault_pre = FAULT_OVERFLOW;
          else if (!a_lt_sp) fault_pre = FAULT_ADDRESS;
        end
      end
      K_DALLOC: begin
        if (n != '0) begin
          if (32'(sp) < 32'(n)) fault_pre = FAULT_UNDERFLOW;
          else if (!a_n_le_sp) fault_pre = FAULT_ADDRESS;
        end
      end
      default: fault_pre = FAULT_NONE;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr == LBW'(LABEL_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_CHECK;
      S_CHECK:  state_next = fin ? S_IDLE : S_READ_X;
      S_READ_X: state_next = is_bin ? S_READ_Y : S_EXEC;
      S_READ_Y: state_next = S_EXEC;
      S_EXEC: begin
        if (fin) state_next = S_IDLE;
        else if (go_alu) state_next = S_ALU;
        else state_next = S_CP_RD;
      end
      S_ALU:    if (fin) state_next = S_IDLE;
      S_CP_RD:  state_next = S_CP_WR;
      S_CP_WR:  state_next = fin ? S_IDLE : S_CP_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    fin         = 1'b0;
    go_alu      = 1'b0;
    o_pv        = 1'b0;
    o_pval      = '0;
    o_fault     = FAULT_NONE;
    sp_next     = sp;
    pc_next     = adv(pc);
    halt_next   = halt;
    k_next      = k;
    t_next      = t;
    y_next      = y;
    lab_r_next  = lab_r;
    mem_raddr   = sp_m1[AW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = sp[AW-1:0];
    mem_wdata   = t;
    lab_raddr   = a[LBW-1:0];
    lab_we      = 1'b0;
    lab_waddr   = a[LBW-1:0];
    lab_wdata   = '0;
    alu_req     = '{start: 1'b0, op: bin_op, x: t, y: y};
    case (state)
      S_CLEAR: begin
        lab_we    = 1'b1;
        lab_waddr = clr;
        lab_wdata = '0;
      end
      S_CHECK: begin
        if (is_bin) mem_raddr = sp_m2[AW-1:0];
        else if (kind == K_LDV) mem_raddr = a_addr;
        if (kind == K_DEFINE) begin
          fin = 1'b0;
        end else if (halt) begin
          fin     = 1'b1;
          pc_next = pc;
        end else if (fault_pre != FAULT_NONE) begin
          fin     = 1'b1;
          o_fault = fault_pre;
        end
      end
      S_READ_X: begin
        t_next     = mem_rdata;
        lab_r_next = lab_rdata;
      end
      S_READ_Y: begin
        y_next = mem_rdata;
      end
      S_EXEC: begin
        case (kind) inside
          K_DEFINE: begin
            if (lab_in_range && !lab_r[PCW]) begin
              // position is reduced by repeated subtraction in the alu step
              go_alu = 1'b1;
              k_next = n;
            end else begin
              fin     = 1'b1;
              pc_next = pc;
            end
          end
          K_LDC, K_RD, K_LDV: begin
            fin       = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = (kind == K_LDC) ? a : ((kind == K_RD) ? item_r.read_value : t);
            sp_next   = sp + SPW'(1);
          end
          K_ADD, K_SUB, K_MULT, K_DIVI, K_AND, K_OR, [K_CME:K_CMAQ]: begin
            if (kind == K_DIVI && y == '0) begin
              fin     = 1'b1;
              o_fault = FAULT_DIV_ZERO;
            end else begin
              go_alu        = 1'b1;
              alu_req.start = 1'b1;
            end
          end
          K_INV, K_NEG: begin
            go_alu  = 1'b1;
            alu_req = '{start: 1'b1, op: ALU_SUB, x: 32'(kind == K_NEG), y: t};
          end
          K_STR: begin
            fin       = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = a_addr;
            sp_next   = sp_m1;
          end
          K_JMP: begin
            fin = 1'b1;
            if (found) pc_next = jump_pc;
          end
          K_JMPF: begin
            fin     = 1'b1;
            sp_next = sp_m1;
            if (t == '0 && found) pc_next = jump_pc;
          end
          K_PRN: begin
            fin     = 1'b1;
            o_pv    = 1'b1;
            o_pval  = t;
            sp_next = sp_m1;
          end
          K_CALL: begin
            fin       = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = 32'(pc) + 32'd1;
            sp_next   = sp + SPW'(1);
            if (found) pc_next = jump_pc;
          end
          K_RETURN: begin
            fin = 1'b1;
            if (t >= 32'(PROGRAM_DEPTH)) begin
              o_fault = FAULT_ADDRESS;
            end else begin
              pc_next = t[PCW-1:0];
              sp_next = sp_m1;
            end
          end
          K_ALLOC, K_DALLOC: begin
            if (n == '0) fin = 1'b1;
            k_next = (kind == K_ALLOC) ? '0 : n;
          end
          K_HLT: begin
            fin       = 1'b1;
            halt_next = 1'b1;
            pc_next   = pc;
          end
          default: fin = 1'b1;
        endcase
      end
      S_ALU: begin
        if (kind == K_DEFINE) begin
          pc_next = pc;
          if (32'(k) >= 32'(PROGRAM_DEPTH)) begin
            k_next = k - 10'(PROGRAM_DEPTH);
          end else begin
            fin       = 1'b1;
            lab_we    = 1'b1;
            lab_wdata = {1'b1, PCW'(k)};
          end
        end else if (alu_rsp.done) begin
          fin       = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = alu_rsp.res;
          if (is_bin) begin
            mem_waddr = sp_m2[AW-1:0];
            sp_next   = sp_m1;
          end else begin
            mem_waddr = sp_m1[AW-1:0];
          end
        end
      end
      S_CP_RD: begin
        // alloc copies upward from the base, dealloc pops downward into the frame
        if (kind == K_ALLOC) mem_raddr = a_addr + AW'(k);
      end
      S_CP_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (kind == K_ALLOC) begin
          mem_waddr = sp[AW-1:0] + AW'(k);
          k_next    = k + 10'd1;
          if (k + 10'd1 == n) begin
            fin     = 1'b1;
            sp_next = sp + SPW'(n);
          end
        end else begin
          mem_waddr = a_addr + AW'(k) - AW'(1);
          k_next    = k - 10'd1;
          sp_next   = sp_m1;
          if (k == 10'd1) fin = 1'b1;
        end
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (lab_we) lab[lab_waddr] <= lab_wdata;
    lab_rdata <= lab[lab_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sp    <= '0;
      pc    <= '0;
      halt  <= 1'b0;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      // program position only moves when an instruction finishes
      if (fin) pc <= pc_next;
      halt  <= halt_next;
      done  <= fin;
      if (state == S_CLEAR) clr <= clr + LBW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) item_r <= item;
    k     <= k_next;
    t     <= t_next;
    y     <= y_next;
    lab_r <= lab_r_next;
    if (fin) begin
      result.next_pc     <= 10'(pc_next);
      result.print_valid <= o_pv;
      result.print_value <= o_pval;
      result.halted      <= halt_next;
      result.fault       <= o_fault;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

@@ hw/rtl/sme_checker.sv @@
// port-level checks of the stack machine executor and their binding
`timescale 1ns / 1ps
`default_nettype none
module sme_checker
  import sme_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire sme_result_t result
);

  // a result word only appears once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  // an accepted word always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // every word passes through idle and check before it finishes, so strobes never touch
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back to back result strobes");

  // a printed value only comes from a clean pop
  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.print_valid) |-> (result.fault == FAULT_NONE))
    else $error("print together with a fault");

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.fault <= FAULT_ADDRESS))
    else $error("fault code out of range");

endmodule

bind stack_machine_executor sme_checker u_sme_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
